FILE: design/mdstep_pkg.sv
`timescale 1ns / 1ps
package mdstep_pkg;

  localparam int SIG_W     = 48;
  localparam int GAIN_W    = 20;
  localparam int RATE_W    = 16;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int SHIFT_W   = 5;
  localparam int GAIN_FRAC = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FB_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RG_FIRST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RG_SECOND = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RG_THIRD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE = 3'd7;

  // Q4.16 adaptation coefficients, 0.4 and 0.005
  localparam logic [GAIN_W-1:0] COEF_LIN = 20'd26214;
  localparam logic [GAIN_W-1:0] COEF_SQ  = 20'd328;

  localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};

  typedef logic signed [SIG_W-1:0] sig_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_LSQ, ST_LIN, ST_SQ, ST_DRIVE, ST_G3, ST_G1,
    ST_R1, ST_G2, ST_R2, ST_R3, ST_GK, ST_SPD, ST_ACC
  } state_e;

  typedef struct packed {
    logic               start;
    sig_t               a;
    sig_t               b;
    logic [SHIFT_W-1:0] shift;
  } mul_req_t;

  function automatic sig_t sat_add(sig_t a, sig_t b);
    logic signed [SIG_W:0] s;
    s = {a[SIG_W-1], a} + {b[SIG_W-1], b};
    if (s[SIG_W] != s[SIG_W-1]) return s[SIG_W] ? SIG_MIN : SIG_MAX;
    return s[SIG_W-1:0];
  endfunction

  function automatic sig_t sat_sub(sig_t a, sig_t b);
    logic signed [SIG_W:0] s;
    s = {a[SIG_W-1], a} - {b[SIG_W-1], b};
    if (s[SIG_W] != s[SIG_W-1]) return s[SIG_W] ? SIG_MIN : SIG_MAX;
    return s[SIG_W-1:0];
  endfunction

endpackage

FILE: design/muscle_dynamics_step.sv
`timescale 1ns / 1ps
// Sequence: a load, then 13 products on one shared multiplier, before done_o
//   rises. A new transaction is accepted only while not busy; out-of-range
//   channels answer in the cycle after acceptance. The receiver cannot stall;
//   each result shows one cycle.
// Reset: asynchronous, active low; config registers take their defaults and
//   all channel state reads as zero with threshold 0.5 (per-entry valid bits).
module muscle_dynamics_step #(
  parameter int CHANNELS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [3:0]                          channel_i,
  input  logic signed [mdstep_pkg::SIG_W-1:0] stimulus_i,
  input  logic                                cfg_we_i,
  input  logic [mdstep_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mdstep_pkg::CFG_W-1:0]        cfg_data_i,
  output logic                                done_o,
  output logic [3:0]                          channel_out_o,
  output logic signed [mdstep_pkg::SIG_W-1:0] length_out_o,
  output logic signed [mdstep_pkg::SIG_W-1:0] speed_out_o,
  output logic signed [mdstep_pkg::SIG_W-1:0] accel_out_o
);

  localparam int SW = mdstep_pkg::SIG_W;
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TW = FRAC_BITS + 1;          // threshold, 0..1 inclusive
  localparam int EW = 5 * SW + TW;            // one packed state entry
  localparam logic [TW-1:0] THR_ONE  = TW'(1) << FRAC_BITS;
  localparam logic [TW-1:0] THR_HALF = TW'(1) << (FRAC_BITS - 1);
  localparam logic [mdstep_pkg::SHIFT_W-1:0] SH_SIG  = mdstep_pkg::SHIFT_W'(FRAC_BITS);
  localparam logic [mdstep_pkg::SHIFT_W-1:0] SH_GAIN =
    mdstep_pkg::SHIFT_W'(mdstep_pkg::GAIN_FRAC);

  // ---------------- configuration registers ----------------
  logic [mdstep_pkg::GAIN_W-1:0] fb1_q, fb2_q, fb3_q, og_q, rg1_q, rg2_q, rg3_q;
  logic [mdstep_pkg::RATE_W-1:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb1_q  <= 20'd48497;
      fb2_q  <= 20'd49152;
      fb3_q  <= 20'd32768;
      og_q   <= 20'd13107;
      rg1_q  <= 20'd21845;
      rg2_q  <= 20'd7123;
      rg3_q  <= 20'd2004;
      rate_q <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mdstep_pkg::CFG_FB_FIRST:  fb1_q  <= cfg_data_i;
        mdstep_pkg::CFG_FB_SECOND: fb2_q  <= cfg_data_i;
        mdstep_pkg::CFG_FB_THIRD:  fb3_q  <= cfg_data_i;
        mdstep_pkg::CFG_OUT_GAIN:  og_q   <= cfg_data_i;
        mdstep_pkg::CFG_RG_FIRST:  rg1_q  <= cfg_data_i;
        mdstep_pkg::CFG_RG_SECOND: rg2_q  <= cfg_data_i;
        mdstep_pkg::CFG_RG_THIRD:  rg3_q  <= cfg_data_i;
        mdstep_pkg::CFG_STEP_RATE: rate_q <= cfg_data_i[mdstep_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- control ----------------
  mdstep_pkg::state_e state_q, state_d;
  logic               accept, oob;
  mdstep_pkg::mul_req_t req;
  logic               mul_done;
  mdstep_pkg::sig_t   mul_res;
  logic               wait_q;    // product in flight for the current state
  logic               is_mul;

  assign accept = start && !busy;
  assign oob    = 9'(channel_i) >= 9'(CHANNELS);
  assign busy   = (state_q != mdstep_pkg::ST_IDLE);

  // ---------------- datapath registers ----------------
  logic [AW-1:0]    ch_q;
  logic [3:0]       chin_q;
  mdstep_pkg::sig_t stim_q, s1_q, s2_q, s3_q, len_q, spd_q;
  logic [TW-1:0]    thr_q;
  mdstep_pkg::sig_t lsq_q, lin_q, acc_q, p1_q, p2_q, p3_q, nlen_q, nspd_q;
  logic [CHANNELS-1:0] vld_q;

  logic [EW-1:0] rdata, wdata;
  logic          we;

  // threshold adaptation: T + (0.4L - 0.005L^2), clamped to [0, 1]
  mdstep_pkg::sig_t      delta;
  logic signed [SW:0]    tsum;
  logic [TW-1:0]         thr_new;

  always_comb begin
    delta = mdstep_pkg::sat_sub(lin_q, mul_res);
    tsum  = $signed({{(SW + 1 - TW){1'b0}}, thr_q}) + $signed({delta[SW-1], delta});
    if (tsum < 0) begin
      thr_new = '0;
    end else if (tsum > $signed({{(SW + 1 - TW){1'b0}}, THR_ONE})) begin
      thr_new = THR_ONE;
    end else begin
      thr_new = tsum[TW-1:0];
    end
  end

  // next state and multiplier operand select
  always_comb begin
    state_d   = state_q;
    is_mul    = 1'b1;
    req.a     = len_q;
    req.b     = len_q;
    req.shift = SH_GAIN;
    case (state_q)
      mdstep_pkg::ST_IDLE: begin
        is_mul = 1'b0;
        if (accept && !oob) state_d = mdstep_pkg::ST_LOAD;
      end
      mdstep_pkg::ST_LOAD: begin
        is_mul  = 1'b0;
        state_d = mdstep_pkg::ST_LSQ;
      end
      mdstep_pkg::ST_LSQ: begin
        req.shift = SH_SIG;
        if (mul_done) state_d = mdstep_pkg::ST_LIN;
      end
      mdstep_pkg::ST_LIN: begin
        req.b = SW'(mdstep_pkg::COEF_LIN);
        if (mul_done) state_d = mdstep_pkg::ST_SQ;
      end
      mdstep_pkg::ST_SQ: begin
        req.a = lsq_q;
        req.b = SW'(mdstep_pkg::COEF_SQ);
        if (mul_done) state_d = mdstep_pkg::ST_DRIVE;
      end
      mdstep_pkg::ST_DRIVE: begin
        req.a     = stim_q;
        req.b     = SW'(thr_q);
        req.shift = SH_SIG;
        if (mul_done) state_d = mdstep_pkg::ST_G3;
      end
      mdstep_pkg::ST_G3: begin
        req.a = s3_q;
        req.b = SW'(fb3_q);
        if (mul_done) state_d = mdstep_pkg::ST_G1;
      end
      mdstep_pkg::ST_G1: begin
        req.a = s1_q;
        req.b = SW'(fb1_q);
        if (mul_done) state_d = mdstep_pkg::ST_R1;
      end
      mdstep_pkg::ST_R1: begin
        req.a = acc_q;
        req.b = SW'(rg1_q);
        if (mul_done) state_d = mdstep_pkg::ST_G2;
      end
      mdstep_pkg::ST_G2: begin
        req.a = s2_q;
        req.b = SW'(fb2_q);
        if (mul_done) state_d = mdstep_pkg::ST_R2;
      end
      mdstep_pkg::ST_R2: begin
        req.a = acc_q;
        req.b = SW'(rg2_q);
        if (mul_done) state_d = mdstep_pkg::ST_R3;
      end
      mdstep_pkg::ST_R3: begin
        req.a = p2_q;
        req.b = SW'(rg3_q);
        if (mul_done) state_d = mdstep_pkg::ST_GK;
      end
      mdstep_pkg::ST_GK: begin
        req.a = p3_q;
        req.b = SW'(og_q);
        if (mul_done) state_d = mdstep_pkg::ST_SPD;
      end
      mdstep_pkg::ST_SPD: begin
        req.a     = acc_q;
        req.b     = SW'(rate_q);
        req.shift = '0;
        if (mul_done) state_d = mdstep_pkg::ST_ACC;
      end
      mdstep_pkg::ST_ACC: begin
        req.a     = acc_q;
        req.b     = SW'(rate_q);
        req.shift = '0;
        if (mul_done) state_d = mdstep_pkg::ST_IDLE;
      end
      default: begin
        is_mul  = 1'b0;
        state_d = mdstep_pkg::ST_IDLE;
      end
    endcase
    req.start = is_mul && !wait_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mdstep_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  mdstep_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  // ---------------- state memory: {thr, V, L, s3, s2, s1} ----------------
  assign we    = (state_q == mdstep_pkg::ST_ACC) && mul_done;
  assign wdata = {thr_q, nspd_q, nlen_q, p3_q, p2_q, p1_q};

  mdstep_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ch_q),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (AW'(channel_i)),
    .rdata_o (rdata)
  );

  // control-side flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= 1'b0;
      vld_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= we || (accept && oob);
      if (mul_done) begin
        wait_q <= 1'b0;
      end else if (req.start) begin
        wait_q <= 1'b1;
      end
      if (we) begin
        vld_q[ch_q] <= 1'b1;
      end
    end
  end

  // payload datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q   <= AW'(channel_i);
      chin_q <= channel_i;
      stim_q <= stimulus_i;
      if (oob) begin
        channel_out_o <= channel_i;
        length_out_o  <= '0;
        speed_out_o   <= '0;
        accel_out_o   <= '0;
      end
    end
    case (state_q)
      mdstep_pkg::ST_LOAD: begin
        // never-written entries read as their reset values
        if (vld_q[ch_q]) begin
          {thr_q, spd_q, len_q, s3_q, s2_q, s1_q} <= rdata;
        end else begin
          {spd_q, len_q, s3_q, s2_q, s1_q} <= '0;
          thr_q <= THR_HALF;
        end
      end
      mdstep_pkg::ST_LSQ:   if (mul_done) lsq_q <= mul_res;
      mdstep_pkg::ST_LIN:   if (mul_done) lin_q <= mul_res;
      mdstep_pkg::ST_SQ:    if (mul_done) thr_q <= thr_new;
      mdstep_pkg::ST_DRIVE: if (mul_done) acc_q <= mul_res;
      mdstep_pkg::ST_G3:    if (mul_done) acc_q <= mdstep_pkg::sat_sub(acc_q, mul_res);
      mdstep_pkg::ST_G1:    if (mul_done) acc_q <= mdstep_pkg::sat_sub(acc_q, mul_res);
      mdstep_pkg::ST_R1:    if (mul_done) p1_q <= mdstep_pkg::sat_add(s1_q, mul_res);
      mdstep_pkg::ST_G2:    if (mul_done) acc_q <= mdstep_pkg::sat_sub(p1_q, mul_res);
      mdstep_pkg::ST_R2:    if (mul_done) p2_q <= mdstep_pkg::sat_add(s2_q, mul_res);
      mdstep_pkg::ST_R3:    if (mul_done) p3_q <= mdstep_pkg::sat_add(s3_q, mul_res);
      mdstep_pkg::ST_GK: begin
        if (mul_done) begin
          nlen_q <= mul_res;
          acc_q  <= mdstep_pkg::sat_sub(mul_res, len_q);
        end
      end
      mdstep_pkg::ST_SPD: begin
        if (mul_done) begin
          nspd_q <= mul_res;
          acc_q  <= mdstep_pkg::sat_sub(mul_res, spd_q);
        end
      end
      mdstep_pkg::ST_ACC: begin
        if (mul_done) begin
          channel_out_o <= chin_q;
          length_out_o  <= nlen_q;
          speed_out_o   <= nspd_q;
          accel_out_o   <= mul_res;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: design/mdstep_ram.sv
`timescale 1ns / 1ps
module mdstep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: design/mdstep_mul.sv
`timescale 1ns / 1ps
// Sign-magnitude multiplier, 48x16 partial product per cycle, then round,
// shift and saturate.
module mdstep_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mdstep_pkg::mul_req_t req_i,
  output logic                done_o,
  output mdstep_pkg::sig_t    res_o
);

  localparam int SW = mdstep_pkg::SIG_W;
  localparam int PW = 2 * SW;

  logic                            busy_q, busy_d;
  logic [1:0]                      cnt_q, cnt_d;
  logic [SW-1:0]                   ma_q, ma_d, mb_q, mb_d;
  logic                            neg_q, neg_d;
  logic [mdstep_pkg::SHIFT_W-1:0]  sh_q, sh_d;
  logic [PW-1:0]                   acc_q, acc_d;
  logic                            done_q, done_d;
  mdstep_pkg::sig_t                res_q, res_d;

  logic [15:0]   chunk;
  logic [63:0]   part;
  logic [PW-1:0] half, rnd, shf;
  logic [SW-1:0] limit, mag;

  always_comb begin
    chunk = 16'(mb_q >> {cnt_q, 4'b0000});
    part  = ma_q * chunk;
    half  = (sh_q == '0) ? '0 : (PW'(1) << (sh_q - 1'b1));
    rnd   = acc_q + half;
    shf   = rnd >> sh_q;
    limit = neg_q ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    mag   = (shf > PW'(limit)) ? limit : shf[SW-1:0];

    busy_d = busy_q;
    cnt_d  = cnt_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    neg_d  = neg_q;
    sh_d   = sh_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    res_d  = res_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      ma_d   = req_i.a[SW-1] ? SW'(-req_i.a) : SW'(req_i.a);
      mb_d   = req_i.b[SW-1] ? SW'(-req_i.b) : SW'(req_i.b);
      neg_d  = req_i.a[SW-1] ^ req_i.b[SW-1];
      sh_d   = req_i.shift;
      acc_d  = '0;
    end else if (busy_q) begin
      if (cnt_q != 2'd3) begin
        acc_d = acc_q + (PW'(part) << {cnt_q, 4'b0000});
        cnt_d = cnt_q + 2'd1;
      end else begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? -$signed(mag) : $signed(mag);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    neg_q <= neg_d;
    sh_q  <= sh_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
